[sv/mfd_pkg.sv]
// Package for the magic-frame deframer: hunt phases, status codes, register
// indexes, CRC constants and the structs passed between the modules.
// No dependencies.
`default_nettype none

package mfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CRC_W    = 16;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned PIDX_W   = 9;
   localparam int unsigned FLEN_W   = 10;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned ADDR_W   = 4;
   localparam int unsigned DATA_W   = 32;

   localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_MSB  = 16'h8000;
   localparam logic [LEN_W-1:0]  FLEN_SAT = 16'd1023;

   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_LEN_REJ = 2'd3;

   localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_ACK_TYPE    = 2'd2;

   typedef enum logic [3:0] {
      PH_MAGIC0  = 4'd0,
      PH_MAGIC1  = 4'd1,
      PH_TYPE    = 4'd2,
      PH_CHAN    = 4'd3,
      PH_SEQ     = 4'd4,
      PH_LEN0    = 4'd5,
      PH_LEN1    = 4'd6,
      PH_CRC0    = 4'd7,
      PH_CRC1    = 4'd8,
      PH_PAYLOAD = 4'd9
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [BYTE_W-1:0] ack_type;
   } cfg_type;

   typedef struct packed {
      logic                consumed;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic [PIDX_W-1:0]   payload_index;
      logic [STATUS_W-1:0] frame_status;
      logic [BYTE_W-1:0]   frame_type;
      logic [BYTE_W-1:0]   frame_channel;
      logic [BYTE_W-1:0]   frame_seq;
      logic [FLEN_W-1:0]   frame_len;
      logic                ack_needed;
   } rsp_type;

endpackage

`default_nettype wire

[sv/mfd_crc16.sv]
// One byte step of CRC16/CCITT-FALSE (poly 0x1021, MSB first).
// Depends on mfd_pkg.
`default_nettype none

module mfd_crc16 (
   input  wire logic [mfd_pkg::CRC_W-1:0]  crc_cur,
   input  wire logic [mfd_pkg::BYTE_W-1:0] data,
   output logic      [mfd_pkg::CRC_W-1:0]  crc_nxt
);
   import mfd_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_cur ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_MSB) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      crc_nxt = c;
   end

endmodule

`default_nettype wire

[sv/mfd_frame_fsm.sv]
// Frame hunt state machine: header capture, payload indexing and CRC check.
// Processes one byte per advance. Depends on mfd_pkg and mfd_crc16.
`default_nettype none

module mfd_frame_fsm #(
   parameter int unsigned MAX_PAYLOAD = 512
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [mfd_pkg::BYTE_W-1:0]  rx_byte,
   input  wire mfd_pkg::cfg_type            cfg,
   output mfd_pkg::rsp_type                 rsp
);
   import mfd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  chan_ff, chan_in;
   logic [BYTE_W-1:0]  seq_ff, seq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CRC_W-1:0]   rcheck_ff, rcheck_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;

   logic [CRC_W-1:0]   crc_base;
   logic [CRC_W-1:0]   crc_step;
   logic [LEN_W-1:0]   len_full;
   logic [CNT_W-1:0]   count_inc;
   logic               len_over;
   logic               last_byte;
   logic [CRC_W-1:0]   check_full;
   logic               zero_len;

   // Type byte restarts the check from its seed
   assign crc_base = (phase_ff == PH_TYPE) ? CRC_INIT : crc_ff;

   mfd_crc16 u_crc (
      .crc_cur (crc_base),
      .data    (rx_byte),
      .crc_nxt (crc_step)
   );

   assign len_full   = {rx_byte, len_ff[BYTE_W-1:0]};
   assign len_over   = len_full > MAX_LEN;
   assign check_full = {rx_byte, rcheck_ff[BYTE_W-1:0]};
   assign zero_len   = (len_ff == '0);
   assign count_inc  = count_ff + CNT_W'(1);
   assign last_byte  = LEN_W'(count_inc) >= len_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_MAGIC0: begin
            if (rx_byte == cfg.sync_first) phase_in = PH_MAGIC1;
         end
         PH_MAGIC1: begin
            if (rx_byte == cfg.sync_second)     phase_in = PH_TYPE;
            else if (rx_byte == cfg.sync_first) phase_in = PH_MAGIC1;
            else                                phase_in = PH_MAGIC0;
         end
         PH_TYPE:    phase_in = PH_CHAN;
         PH_CHAN:    phase_in = PH_SEQ;
         PH_SEQ:     phase_in = PH_LEN0;
         PH_LEN0:    phase_in = PH_LEN1;
         PH_LEN1:    phase_in = len_over ? PH_MAGIC0 : PH_CRC0;
         PH_CRC0:    phase_in = PH_CRC1;
         PH_CRC1:    phase_in = zero_len ? PH_MAGIC0 : PH_PAYLOAD;
         PH_PAYLOAD: phase_in = last_byte ? PH_MAGIC0 : PH_PAYLOAD;
         default:    phase_in = PH_MAGIC0;
      endcase
   end

   // Held fields and result
   always_comb begin
      type_in   = type_ff;
      chan_in   = chan_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      rcheck_in = rcheck_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;

      rsp.consumed      = 1'b1;
      rsp.payload_valid = 1'b0;
      rsp.payload_byte  = '0;
      rsp.payload_index = '0;
      rsp.frame_status  = STATUS_NONE;
      rsp.ack_needed    = 1'b0;

      case (phase_ff)
         PH_MAGIC0: begin
            rsp.consumed = (rx_byte == cfg.sync_first);
         end
         PH_MAGIC1: ;
         PH_TYPE: begin
            type_in = rx_byte;
            crc_in  = crc_step;
         end
         PH_CHAN: begin
            chan_in = rx_byte;
            crc_in  = crc_step;
         end
         PH_SEQ: begin
            seq_in = rx_byte;
            crc_in = crc_step;
         end
         PH_LEN0: begin
            len_in = LEN_W'(rx_byte);
            crc_in = crc_step;
         end
         PH_LEN1: begin
            len_in = len_full;
            crc_in = crc_step;
            if (len_over) rsp.frame_status = STATUS_LEN_REJ;
         end
         PH_CRC0: begin
            rcheck_in = CRC_W'(rx_byte);
         end
         PH_CRC1: begin
            rcheck_in = check_full;
            count_in  = '0;
            if (zero_len) begin
               if (crc_ff == check_full) begin
                  rsp.frame_status = STATUS_GOOD;
                  rsp.ack_needed   = (type_ff != cfg.ack_type);
               end else begin
                  rsp.frame_status = STATUS_CRC_ERR;
               end
            end
         end
         PH_PAYLOAD: begin
            rsp.payload_valid = 1'b1;
            rsp.payload_byte  = rx_byte;
            rsp.payload_index = PIDX_W'(count_ff);
            crc_in            = crc_step;
            count_in          = count_inc;
            if (last_byte) begin
               if (crc_step == rcheck_ff) begin
                  rsp.frame_status = STATUS_GOOD;
                  rsp.ack_needed   = (type_ff != cfg.ack_type);
               end else begin
                  rsp.frame_status = STATUS_CRC_ERR;
               end
            end
         end
         default: begin
            rsp.consumed = 1'b0;
         end
      endcase

      rsp.frame_type    = type_in;
      rsp.frame_channel = chan_in;
      rsp.frame_seq     = seq_in;
      rsp.frame_len     = (len_in > FLEN_SAT) ? FLEN_W'(FLEN_SAT) : len_in[FLEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC0;
         type_ff   <= '0;
         chan_ff   <= '0;
         seq_ff    <= '0;
         len_ff    <= '0;
         rcheck_ff <= '0;
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
      end else if (advance) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         chan_ff   <= chan_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         rcheck_ff <= rcheck_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

`default_nettype wire

[sv/magic_frame_deframer_crc16_unit.sv]
// Magic-frame deframer with CRC16/CCITT-FALSE check: top level.
// Depends on mfd_pkg and mfd_frame_fsm (which uses mfd_crc16).
//
// Usage:
//   Request channel (req_valid/req_ready/req_rx_data) carries one received
//   byte per request. Every request yields exactly one response on the rsp_
//   channel, in order: consumed flag, payload byte and index, frame status
//   (none, good, CRC error, length rejected), the held header fields and
//   ack_needed for good frames whose type is not the ack type.
//   The CSR port (APB style, pready tied high) holds the two sync bytes at
//   0x0 and 0x4 and the ack frame type at 0x8; write it only while idle.
//   The byte sits in the input register, the hunt state machine processes
//   it combinationally and the result lands in the response register,
//   which drives rsp_valid.
//   Throughput: one byte per cycle while responses are taken; the bytewise
//   combinational CRC update and phase decode set that figure.
//   Reset (synchronous, active high) clears the valid flags of both pipeline
//   registers, the hunt state (waiting for the first sync byte) and all CSRs.
//   When the receiver stalls, the response register holds, the input
//   register fills, and req_ready drops until the response is taken.
`default_nettype none

module magic_frame_deframer_crc16_unit #(
   parameter int unsigned MAX_PAYLOAD = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_rx_data,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_consumed,
   output logic                               rsp_payload_valid,
   output logic [7:0]                         rsp_payload_byte,
   output logic [8:0]                         rsp_payload_index,
   output logic [1:0]                         rsp_frame_status,
   output logic [7:0]                         rsp_frame_type,
   output logic [7:0]                         rsp_frame_channel,
   output logic [7:0]                         rsp_frame_seq,
   output logic [9:0]                         rsp_frame_len,
   output logic                               rsp_ack_needed,

   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mfd_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [mfd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic      [mfd_pkg::DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import mfd_pkg::*;

   // CSRs
   cfg_type             cfg_ff;
   logic                csr_wr;
   logic [1:0]          csr_idx;

   // Input register
   logic                in_valid_ff;
   logic [BYTE_W-1:0]   in_byte_ff;

   // Response register
   logic                out_valid_ff;
   rsp_type             out_ff;
   rsp_type             fsm_rsp;

   logic                advance;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SYNC_FIRST:  cfg_ff.sync_first  <= csr_pwdata[BYTE_W-1:0];
            REG_SYNC_SECOND: cfg_ff.sync_second <= csr_pwdata[BYTE_W-1:0];
            REG_ACK_TYPE:    cfg_ff.ack_type    <= csr_pwdata[BYTE_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SYNC_FIRST:  csr_prdata = DATA_W'(cfg_ff.sync_first);
         REG_SYNC_SECOND: csr_prdata = DATA_W'(cfg_ff.sync_second);
         REG_ACK_TYPE:    csr_prdata = DATA_W'(cfg_ff.ack_type);
         default:         csr_prdata = '0;
      endcase
   end

   // Advance the held byte whenever the response register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_data;
      end
   end

   mfd_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .rsp     (fsm_rsp)
   );

   // Hold the response until taken; load a new one on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= fsm_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_consumed      = out_ff.consumed;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_frame_status  = out_ff.frame_status;
   assign rsp_frame_type    = out_ff.frame_type;
   assign rsp_frame_channel = out_ff.frame_channel;
   assign rsp_frame_seq     = out_ff.frame_seq;
   assign rsp_frame_len     = out_ff.frame_len;
   assign rsp_ack_needed    = out_ff.ack_needed;

endmodule

`default_nettype wire
